// ----- rtl/npci_pkg.sv -----
// ----------------------------------------------------------------------------
// npci_pkg
// Shared types and constants of the nearest palette color indexer.
// ----------------------------------------------------------------------------
package npci_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int COLOR_W       = 8;
    localparam int ALPHA_W       = 8;
    localparam int ENTRIES_W     = 9;
    localparam int INDEX_OUT_W   = 8;
    localparam int SQ_W          = 2 * COLOR_W;
    localparam int GAP_W         = SQ_W + 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = ENTRIES_W;

    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET   = ENTRIES_W'(256);
    localparam logic [ALPHA_W-1:0]   THRESHOLD_RESET = ALPHA_W'(128);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [GAP_W-1:0] gap;
        logic             busy;
    } pipe_out_t;

    typedef struct packed {
        logic                   valid;
        logic [INDEX_OUT_W-1:0] index;
        logic                   frame_end;
    } result_t;

endpackage

// ----- rtl/nearest_palette_color_indexer.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_indexer
// Maps RGBA pixels to the index of the nearest color of a loaded palette.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a transaction with operation = load
// writes red/green/blue into palette slot entry_index and gives
// no result. A transaction with operation = pixel yields one result on the
// output channel (out_valid / out_stall) carrying palette_index and a copy
// of frame_end.
// An opaque pixel is compared with entries 0 .. N-1 (N = entries_in_use,
// capped at the palette depth), one palette read per cycle from the single
// read port of the palette memory, through a three-stage distance pipeline.
// A pixel with alpha below alpha_threshold, or any pixel while N is 0,
// skips the scan and maps to index 0. in_stall is high while a pixel is
// in work; loads are taken every cycle otherwise.
// The output register holds one finished result; while the receiver stalls,
// the next pixel is still taken and searched, and waits at its end.
// Reset sets entries_in_use to 256 and alpha_threshold to 128 and empties
// the pipeline; palette contents are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color_indexer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [npci_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npci_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [7:0]                       entry_index,
    input  logic [npci_pkg::COLOR_W-1:0]     red,
    input  logic [npci_pkg::COLOR_W-1:0]     green,
    input  logic [npci_pkg::COLOR_W-1:0]     blue,
    input  logic [npci_pkg::ALPHA_W-1:0]     alpha,
    input  logic                             frame_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [npci_pkg::INDEX_OUT_W-1:0] palette_index,
    output logic                             frame_end_out
);
    import npci_pkg::*;

    logic [ENTRIES_W-1:0]   entries_in_use_reg;
    logic [ALPHA_W-1:0]     alpha_threshold_reg;
    logic                   out_valid_reg;
    logic [INDEX_OUT_W-1:0] palette_index_reg;
    logic                   frame_end_out_reg;

    logic             accept;
    logic             pixel_start;
    logic             load_write;
    logic             busy;
    logic             result_take;
    rgb_t             in_color;
    rgb_t             scan_color;
    rgb_t             rd_data;
    rd_req_t          rd_req;
    pipe_out_t        pipe;
    result_t          result;
    logic             issue_valid;
    logic [IDX_W-1:0] issue_idx;

    always_comb
    begin
        in_stall       = busy;
        accept         = in_valid && !busy;
        pixel_start    = accept && (operation == OP_PIXEL);
        load_write     = accept && (operation == OP_LOAD)
                         && (ENTRIES_W'(entry_index) < ENTRIES_W'(PALETTE_DEPTH));
        in_color.red   = red;
        in_color.green = green;
        in_color.blue  = blue;
        result_take    = result.valid && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg  <= ENTRIES_RESET;
            alpha_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ENTRIES_IN_USE:  entries_in_use_reg  <= cfg_data;
                CFG_ALPHA_THRESHOLD: alpha_threshold_reg <= cfg_data[ALPHA_W-1:0];
                default:             entries_in_use_reg  <= entries_in_use_reg;
            endcase
        end
    end

    npci_palette_ram u_ram (
        .clk     (clk),
        .wr_en   (load_write),
        .wr_addr (entry_index[IDX_W-1:0]),
        .wr_data (in_color),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    npci_scan_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_start     (pixel_start),
        .pixel_color     (in_color),
        .alpha           (alpha),
        .frame_end       (frame_end),
        .entries_in_use  (entries_in_use_reg),
        .alpha_threshold (alpha_threshold_reg),
        .pipe            (pipe),
        .result_take     (result_take),
        .busy            (busy),
        .rd_req          (rd_req),
        .issue_valid     (issue_valid),
        .issue_idx       (issue_idx),
        .scan_color      (scan_color),
        .result          (result)
    );

    npci_gap_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (issue_valid),
        .beat_idx   (issue_idx),
        .entry      (rd_data),
        .pixel      (scan_color),
        .pipe       (pipe)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            palette_index_reg <= result.index;
            frame_end_out_reg <= result.frame_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign palette_index = palette_index_reg;
    assign frame_end_out = frame_end_out_reg;

endmodule

// ----- rtl/npci_palette_ram.sv -----
// ----------------------------------------------------------------------------
// npci_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npci_palette_ram (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [npci_pkg::IDX_W-1:0] wr_addr,
    input  npci_pkg::rgb_t           wr_data,
    input  npci_pkg::rd_req_t        rd_req,
    output npci_pkg::rgb_t           rd_data
);
    import npci_pkg::*;

    rgb_t mem [PALETTE_DEPTH];
    rgb_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/npci_gap_pipe.sv -----
// ----------------------------------------------------------------------------
// npci_gap_pipe
// Three-stage squared RGB distance: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module npci_gap_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       beat_valid,
    input  logic [npci_pkg::IDX_W-1:0] beat_idx,
    input  npci_pkg::rgb_t             entry,
    input  npci_pkg::rgb_t             pixel,
    output npci_pkg::pipe_out_t        pipe
);
    import npci_pkg::*;

    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [COLOR_W-1:0] dr_reg;
    logic [COLOR_W-1:0] dg_reg;
    logic [COLOR_W-1:0] db_reg;
    logic [COLOR_W-1:0] dr_next;
    logic [COLOR_W-1:0] dg_next;
    logic [COLOR_W-1:0] db_next;

    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [SQ_W-1:0]    sr_reg;
    logic [SQ_W-1:0]    sg_reg;
    logic [SQ_W-1:0]    sb_reg;

    logic               s3_valid_reg;
    logic [IDX_W-1:0]   s3_idx_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [GAP_W-1:0]   gap_next;

    always_comb
    begin
        dr_next = (pixel.red > entry.red) ? pixel.red - entry.red : entry.red - pixel.red;
        dg_next = (pixel.green > entry.green) ? pixel.green - entry.green
                                              : entry.green - pixel.green;
        db_next = (pixel.blue > entry.blue) ? pixel.blue - entry.blue
                                            : entry.blue - pixel.blue;
        gap_next = GAP_W'(sr_reg) + GAP_W'(sg_reg) + GAP_W'(sb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= beat_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= beat_idx;
        dr_reg     <= dr_next;
        dg_reg     <= dg_next;
        db_reg     <= db_next;
        s2_idx_reg <= s1_idx_reg;
        sr_reg     <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sg_reg     <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sb_reg     <= SQ_W'(db_reg) * SQ_W'(db_reg);
        s3_idx_reg <= s2_idx_reg;
        gap_reg    <= gap_next;
    end

    always_comb
    begin
        pipe.valid = s3_valid_reg;
        pipe.idx   = s3_idx_reg;
        pipe.gap   = gap_reg;
        pipe.busy  = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    end

endmodule

// ----- rtl/npci_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// npci_scan_ctrl
// Sequences palette reads for one pixel and keeps the nearest entry so far.
// ----------------------------------------------------------------------------
module npci_scan_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_start,
    input  npci_pkg::rgb_t                 pixel_color,
    input  logic [npci_pkg::ALPHA_W-1:0]   alpha,
    input  logic                           frame_end,
    input  logic [npci_pkg::ENTRIES_W-1:0] entries_in_use,
    input  logic [npci_pkg::ALPHA_W-1:0]   alpha_threshold,
    input  npci_pkg::pipe_out_t            pipe,
    input  logic                           result_take,
    output logic                           busy,
    output npci_pkg::rd_req_t              rd_req,
    output logic                           issue_valid,
    output logic [npci_pkg::IDX_W-1:0]     issue_idx,
    output npci_pkg::rgb_t                 scan_color,
    output npci_pkg::result_t              result
);
    import npci_pkg::*;

    scan_state_t      state_reg;
    scan_state_t      state_next;
    rgb_t             color_reg;
    logic             frame_end_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             issue_valid_reg;
    logic [IDX_W-1:0] issue_idx_reg;
    logic [GAP_W-1:0] best_gap_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic [CNT_W-1:0] count_sat;
    logic             opaque;
    logic             last_addr;
    logic             better;

    always_comb
    begin
        count_sat = (entries_in_use > ENTRIES_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                                 : CNT_W'(entries_in_use);
        opaque    = (alpha >= alpha_threshold);
        last_addr = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
        better    = pipe.valid && (pipe.gap < best_gap_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixel_start)
                begin
                    state_next = (opaque && (count_sat != '0)) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!issue_valid_reg && !pipe.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy             = (state_reg != ST_IDLE);
        rd_req.en        = (state_reg == ST_SCAN);
        rd_req.addr      = addr_reg;
        issue_valid      = issue_valid_reg;
        issue_idx        = issue_idx_reg;
        scan_color       = color_reg;
        result.valid     = (state_reg == ST_DONE);
        result.index     = INDEX_OUT_W'(best_idx_reg);
        result.frame_end = frame_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            addr_reg        <= '0;
            count_reg       <= '0;
            issue_valid_reg <= 1'b0;
            issue_idx_reg   <= '0;
            best_gap_reg    <= '1;
            best_idx_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_valid_reg <= (state_reg == ST_SCAN);
            issue_idx_reg   <= addr_reg;
            if (pixel_start)
            begin
                addr_reg     <= '0;
                count_reg    <= count_sat;
                best_gap_reg <= '1;
                best_idx_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                if (better)
                begin
                    best_gap_reg <= pipe.gap;
                    best_idx_reg <= pipe.idx;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_start)
        begin
            color_reg     <= pixel_color;
            frame_end_reg <= frame_end;
        end
    end

    a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!issue_valid_reg && !pipe.busy))
        else $error("result shown while distances still in flight");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(addr_reg) < count_reg))
        else $error("read address beyond entries in use");

    a_beat_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance arrived outside a scan");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ((best_idx_reg == '0) || (CNT_W'(best_idx_reg) < count_reg)))
        else $error("best index beyond entries in use");

endmodule
